// ----- rtl/qte_pkg.sv -----
// Shared types and constants of the quaternion to Euler angle unit.
// Depends on nothing; used by every module under rtl/.
`default_nettype none
package qte_pkg;

	typedef logic [1:0] pole_case_t;

	localparam pole_case_t CASE_GENERAL = 2'd0;
	localparam pole_case_t CASE_NORTH   = 2'd1;
	localparam pole_case_t CASE_SOUTH   = 2'd2;

	localparam logic [15:0] THR_RESET = 16'd32735;

	// angle scale: degrees * 2^INT_FRAC
	localparam int INT_FRAC = 20;

	// operand width into the atan2 lanes; normalized magnitudes sit in [2^40, 2^41)
	localparam int OPW = 42;
	// CORDIC datapath width, leaves room for the gain
	localparam int CW = 45;
	// angle accumulator width
	localparam int ZW = 30;
	localparam int NORM_STEPS = 6;

	// integer square root of a 57 bit value
	localparam int SQW = 58;
	localparam int SQRT_STEPS = 29;
	localparam int SQRT_RES_W = 29;

	localparam logic signed [ZW-1:0] DEG90  = 30'sd94371840;
	localparam logic signed [ZW-1:0] DEG180 = 30'sd188743680;

	localparam int ATAN_LEN = 24;
	localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_LEN] = '{
		30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
		30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
		30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
		30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
		30'sd917,      30'sd458,      30'sd229,      30'sd115,
		30'sd57,       30'sd29,       30'sd14,       30'sd7
	};

endpackage
`default_nettype wire

// ----- rtl/qte_sqrt_cell.sv -----
// One registered step of the digit-by-digit integer square root.
// Depends on qte_pkg.
`default_nettype none
module qte_sqrt_cell #(
	parameter int K = 0
) (
	input  logic                    clk,
	input  logic [qte_pkg::SQW-1:0] v_in,
	input  logic [qte_pkg::SQW-1:0] r_in,
	output logic [qte_pkg::SQW-1:0] v_out,
	output logic [qte_pkg::SQW-1:0] r_out
);
	import qte_pkg::*;

	localparam logic [SQW-1:0] BIT = SQW'(64'd1 << (2 * K));

	logic [SQW:0]   trial;
	logic [SQW-1:0] v_q, r_q;

	assign trial = {1'b0, r_in} + {1'b0, BIT};

	always_ff @(posedge clk) begin
		if ({1'b0, v_in} >= trial) begin
			v_q <= v_in - trial[SQW-1:0];
			r_q <= (r_in >> 1) + BIT;
		end else begin
			v_q <= v_in;
			r_q <= r_in >> 1;
		end
	end

	assign v_out = v_q;
	assign r_out = r_q;

endmodule
`default_nettype wire

// ----- rtl/qte_cordic_cell.sv -----
// One registered vectoring CORDIC iteration, angle in degrees * 2^20.
// Depends on qte_pkg (arctangent table, widths).
`default_nettype none
module qte_cordic_cell #(
	parameter int SHIFT = 0
) (
	input  logic                          clk,
	input  logic signed [qte_pkg::CW-1:0] x_in,
	input  logic signed [qte_pkg::CW-1:0] y_in,
	input  logic signed [qte_pkg::ZW-1:0] z_in,
	output logic signed [qte_pkg::CW-1:0] x_out,
	output logic signed [qte_pkg::CW-1:0] y_out,
	output logic signed [qte_pkg::ZW-1:0] z_out
);
	import qte_pkg::*;

	logic signed [CW-1:0] xs, ys, x_q, y_q;
	logic signed [ZW-1:0] z_q;

	assign xs = x_in >>> SHIFT;
	assign ys = y_in >>> SHIFT;

	always_ff @(posedge clk) begin
		if (y_in > 0) begin
			x_q <= x_in + ys;
			y_q <= y_in - xs;
			z_q <= z_in + ATAN_TAB[SHIFT];
		end else begin
			x_q <= x_in - ys;
			y_q <= y_in + xs;
			z_q <= z_in - ATAN_TAB[SHIFT];
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;

endmodule
`default_nettype wire

// ----- rtl/qte_atan_lane.sv -----
// Pipelined atan2 lane: axis check, normalizing shift, quadrant fold, CORDIC cells.
// Depends on qte_pkg and qte_cordic_cell.
`default_nettype none
module qte_atan_lane #(
	parameter int STAGES = 16
) (
	input  logic                           clk,
	input  logic signed [qte_pkg::OPW-1:0] y_in,
	input  logic signed [qte_pkg::OPW-1:0] x_in,
	output logic signed [qte_pkg::ZW-1:0]  z_out
);
	import qte_pkg::*;

	localparam int LAT = NORM_STEPS + 1 + STAGES;

	logic                 sp_hit;
	logic signed [ZW-1:0] sp_val;
	logic                 sp_hit_q [LAT];
	logic signed [ZW-1:0] sp_val_q [LAT];

	// exact answers on the axes
	always_comb begin
		sp_hit = 1'b1;
		sp_val = '0;
		if (x_in == 0) begin
			if (y_in > 0)
				sp_val = DEG90;
			else if (y_in < 0)
				sp_val = -DEG90;
		end else if (y_in == 0) begin
			if (x_in < 0)
				sp_val = DEG180;
		end else begin
			sp_hit = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		sp_hit_q[0] <= sp_hit;
		sp_val_q[0] <= sp_val;
		for (int i = 1; i < LAT; i++) begin
			sp_hit_q[i] <= sp_hit_q[i-1];
			sp_val_q[i] <= sp_val_q[i-1];
		end
	end

	// normalize: shift until the larger magnitude reaches 2^(OPW-2)
	logic signed [OPW-1:0] sx [NORM_STEPS+1];
	logic signed [OPW-1:0] sy [NORM_STEPS+1];
	logic signed [OPW-1:0] nx_q [NORM_STEPS];
	logic signed [OPW-1:0] ny_q [NORM_STEPS];

	assign sx[0] = x_in;
	assign sy[0] = y_in;

	for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
		localparam int AMT = 1 << (NORM_STEPS - 1 - k);
		localparam logic signed [OPW-1:0] BND = OPW'(64'd1 << (OPW - 1 - AMT));

		always_ff @(posedge clk) begin
			if (sx[k] > -BND && sx[k] < BND && sy[k] > -BND && sy[k] < BND) begin
				nx_q[k] <= sx[k] <<< AMT;
				ny_q[k] <= sy[k] <<< AMT;
			end else begin
				nx_q[k] <= sx[k];
				ny_q[k] <= sy[k];
			end
		end

		assign sx[k+1] = nx_q[k];
		assign sy[k+1] = ny_q[k];
	end

	// fold the left half plane by +-90 degrees
	logic signed [CW-1:0] xe, ye, rx_q, ry_q;
	logic signed [ZW-1:0] rz_q;

	assign xe = CW'(sx[NORM_STEPS]);
	assign ye = CW'(sy[NORM_STEPS]);

	always_ff @(posedge clk) begin
		if (xe < 0) begin
			if (ye >= 0) begin
				rx_q <= ye;
				ry_q <= -xe;
				rz_q <= DEG90;
			end else begin
				rx_q <= -ye;
				ry_q <= xe;
				rz_q <= -DEG90;
			end
		end else begin
			rx_q <= xe;
			ry_q <= ye;
			rz_q <= '0;
		end
	end

	logic signed [CW-1:0] cx [STAGES+1];
	logic signed [CW-1:0] cy [STAGES+1];
	logic signed [ZW-1:0] cz [STAGES+1];

	assign cx[0] = rx_q;
	assign cy[0] = ry_q;
	assign cz[0] = rz_q;

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		qte_cordic_cell #(.SHIFT(i)) u_cell (
			.clk   (clk),
			.x_in  (cx[i]),
			.y_in  (cy[i]),
			.z_in  (cz[i]),
			.x_out (cx[i+1]),
			.y_out (cy[i+1]),
			.z_out (cz[i+1])
		);
	end

	assign z_out = sp_hit_q[LAT-1] ? sp_val_q[LAT-1] : cz[STAGES];

endmodule
`default_nettype wire

// ----- rtl/quaternion_to_euler_degrees_unit.sv -----
// Top level: quaternion (Q2.14) to pitch, yaw and roll in degrees with pole check.
// Depends on qte_pkg, qte_sqrt_cell, qte_atan_lane (and qte_cordic_cell below it).
//
// Usage:
//  - Input: pulse start with quat_x/y/z/w; a beat is taken on every edge with start
//    high and busy low. busy stays low, so a new quaternion can enter every cycle.
//  - Config: pole_threshold is written through cfg_valid/cfg_ready/cfg_data;
//    cfg_ready is always high. Write it only while no beat is in flight.
//  - Output: done is high for one cycle with pitch_deg, yaw_deg, roll_deg
//    (degrees * 2^ANGLE_FRAC_BITS, wrapped to [0,360)) and pole_case.
//  - Pipeline: 4 product/compare stages, 29 square root cells, 6 normalize
//    stages, one quadrant fold, one cell per CORDIC iteration and 2 output
//    stages. Throughput is one quaternion per cycle.
//  - The result side has no back pressure: every result appears once on done.
//  - Reset clears the pipeline valid bits and loads pole_threshold with 32735.
`default_nettype none
module quaternion_to_euler_degrees_unit #(
	parameter int ANGLE_FRAC_BITS = 7,
	parameter int CORDIC_STAGES   = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [15:0]  quat_x,
	input  logic signed [15:0]  quat_y,
	input  logic signed [15:0]  quat_z,
	input  logic signed [15:0]  quat_w,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data,
	output logic                done,
	output logic [15:0]         pitch_deg,
	output logic [15:0]         yaw_deg,
	output logic [15:0]         roll_deg,
	output qte_pkg::pole_case_t pole_case
);
	import qte_pkg::*;

	localparam int LANE_LAT = NORM_STEPS + 1 + CORDIC_STAGES;
	localparam int LAT      = 4 + SQRT_STEPS + LANE_LAT + 2;
	localparam int CDLY     = SQRT_STEPS + LANE_LAT;
	localparam int SH       = INT_FRAC - ANGLE_FRAC_BITS;
	localparam logic signed [31:0] HALF = 32'sd1 <<< (SH - 1);
	localparam logic signed [31:0] FULL = 32'(360 * (1 << ANGLE_FRAC_BITS));
	localparam logic [15:0] PITCH_N = 16'(90 * (1 << ANGLE_FRAC_BITS));
	localparam logic signed [29:0]     S_ONE  = 30'sd268435456;
	localparam logic signed [OPW-1:0]  ONE_OP = OPW'(64'd1 << 28);
	localparam logic [56:0]            C_FULL = 57'd1 << 56;

	logic accept;
	logic [15:0] thr_q;
	logic [LAT-1:0] vld_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			vld_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				thr_q <= cfg_data;
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	// stage 1: products
	logic signed [31:0] p_xx_s1, p_yy_s1, p_zz_s1, p_ww_s1, p_xw_s1;
	logic signed [31:0] p_yz_s1, p_wy_s1, p_zx_s1, p_wz_s1, p_xy_s1;
	logic signed [15:0] qx_s1, qy_s1;

	always_ff @(posedge clk) begin
		p_xx_s1 <= quat_x * quat_x;
		p_yy_s1 <= quat_y * quat_y;
		p_zz_s1 <= quat_z * quat_z;
		p_ww_s1 <= quat_w * quat_w;
		p_xw_s1 <= quat_x * quat_w;
		p_yz_s1 <= quat_y * quat_z;
		p_wy_s1 <= quat_w * quat_y;
		p_zx_s1 <= quat_z * quat_x;
		p_wz_s1 <= quat_w * quat_z;
		p_xy_s1 <= quat_x * quat_y;
		qx_s1   <= quat_x;
		qy_s1   <= quat_y;
	end

	// stage 2: sums
	logic [32:0]            unit_s2;
	logic signed [32:0]     test_s2;
	logic signed [OPW-1:0]  yy_s2, yx_s2, ry_s2, rx_s2;
	logic signed [15:0]     qx_s2, qy_s2;

	always_ff @(posedge clk) begin
		unit_s2 <= 33'(p_xx_s1) + 33'(p_yy_s1) + 33'(p_zz_s1) + 33'(p_ww_s1);
		test_s2 <= 33'(p_xw_s1) - 33'(p_yz_s1);
		yy_s2   <= (OPW'(p_wy_s1) + OPW'(p_zx_s1)) <<< 1;
		yx_s2   <= ONE_OP - ((OPW'(p_xx_s1) + OPW'(p_yy_s1)) <<< 1);
		ry_s2   <= (OPW'(p_wz_s1) + OPW'(p_xy_s1)) <<< 1;
		rx_s2   <= ONE_OP - ((OPW'(p_zz_s1) + OPW'(p_xx_s1)) <<< 1);
		qx_s2   <= qx_s1;
		qy_s2   <= qy_s1;
	end

	// stage 3: pole limit, saturated asin argument and its square
	logic signed [33:0] t2;
	logic signed [29:0] s_sat;
	logic signed [59:0] sq_full;

	assign t2 = 34'(test_s2) <<< 1;

	always_comb begin
		if (t2 > 34'(S_ONE))
			s_sat = S_ONE;
		else if (t2 < -34'(S_ONE))
			s_sat = -S_ONE;
		else
			s_sat = t2[29:0];
	end

	assign sq_full = s_sat * s_sat;

	logic [48:0]            lim_s3;
	logic signed [32:0]     test_s3;
	logic [56:0]            sq_s3;
	logic signed [29:0]     s_s3;
	logic signed [OPW-1:0]  yy_s3, yx_s3, ry_s3, rx_s3;
	logic signed [15:0]     qx_s3, qy_s3;

	always_ff @(posedge clk) begin
		lim_s3  <= thr_q * unit_s2;
		test_s3 <= test_s2;
		sq_s3   <= sq_full[56:0];
		s_s3    <= s_sat;
		yy_s3   <= yy_s2;
		yx_s3   <= yx_s2;
		ry_s3   <= ry_s2;
		rx_s3   <= rx_s2;
		qx_s3   <= qx_s2;
		qy_s3   <= qy_s2;
	end

	// stage 4: pole decision, radicand for the cosine
	logic signed [50:0] tl, lm;
	pole_case_t         case_c;

	assign tl = 51'(test_s3) <<< 16;
	assign lm = {2'b00, lim_s3};

	always_comb begin
		if (tl > lm)
			case_c = CASE_NORTH;
		else if (tl < -lm)
			case_c = CASE_SOUTH;
		else
			case_c = CASE_GENERAL;
	end

	pole_case_t             case_s4;
	logic [56:0]            cin_s4;
	logic signed [29:0]     s_s4;
	logic signed [OPW-1:0]  yy_s4, yx_s4, ry_s4, rx_s4;
	logic signed [15:0]     qx_s4, qy_s4;

	always_ff @(posedge clk) begin
		case_s4 <= case_c;
		cin_s4  <= C_FULL - sq_s3;
		s_s4    <= s_s3;
		yy_s4   <= yy_s3;
		yx_s4   <= yx_s3;
		ry_s4   <= ry_s3;
		rx_s4   <= rx_s3;
		qx_s4   <= qx_s3;
		qy_s4   <= qy_s3;
	end

	// square root cells
	logic [SQW-1:0] sv [SQRT_STEPS+1];
	logic [SQW-1:0] sr [SQRT_STEPS+1];

	assign sv[0] = {1'b0, cin_s4};
	assign sr[0] = '0;

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		qte_sqrt_cell #(.K(SQRT_STEPS - 1 - j)) u_sqrt (
			.clk   (clk),
			.v_in  (sv[j]),
			.r_in  (sr[j]),
			.v_out (sv[j+1]),
			.r_out (sr[j+1])
		);
	end

	// side data held alongside the square root
	logic signed [29:0]     s_d_q  [SQRT_STEPS];
	logic signed [OPW-1:0]  yy_d_q [SQRT_STEPS];
	logic signed [OPW-1:0]  yx_d_q [SQRT_STEPS];
	logic signed [OPW-1:0]  ry_d_q [SQRT_STEPS];
	logic signed [OPW-1:0]  rx_d_q [SQRT_STEPS];
	logic signed [15:0]     qx_d_q [SQRT_STEPS];
	logic signed [15:0]     qy_d_q [SQRT_STEPS];
	pole_case_t             case_d_q [CDLY];

	always_ff @(posedge clk) begin
		s_d_q[0]    <= s_s4;
		yy_d_q[0]   <= yy_s4;
		yx_d_q[0]   <= yx_s4;
		ry_d_q[0]   <= ry_s4;
		rx_d_q[0]   <= rx_s4;
		qx_d_q[0]   <= qx_s4;
		qy_d_q[0]   <= qy_s4;
		case_d_q[0] <= case_s4;
		for (int i = 1; i < SQRT_STEPS; i++) begin
			s_d_q[i]  <= s_d_q[i-1];
			yy_d_q[i] <= yy_d_q[i-1];
			yx_d_q[i] <= yx_d_q[i-1];
			ry_d_q[i] <= ry_d_q[i-1];
			rx_d_q[i] <= rx_d_q[i-1];
			qx_d_q[i] <= qx_d_q[i-1];
			qy_d_q[i] <= qy_d_q[i-1];
		end
		for (int i = 1; i < CDLY; i++)
			case_d_q[i] <= case_d_q[i-1];
	end

	// lane operands
	logic                  pole_d;
	logic signed [OPW-1:0] lp_y, lp_x, ly_y, ly_x;
	logic signed [ZW-1:0]  z_p, z_y, z_r;

	assign pole_d = case_d_q[SQRT_STEPS-1] != CASE_GENERAL;
	assign lp_y   = OPW'(s_d_q[SQRT_STEPS-1]);
	assign lp_x   = OPW'(sr[SQRT_STEPS][SQRT_RES_W-1:0]);
	assign ly_y   = pole_d ? OPW'(qy_d_q[SQRT_STEPS-1]) : yy_d_q[SQRT_STEPS-1];
	assign ly_x   = pole_d ? OPW'(qx_d_q[SQRT_STEPS-1]) : yx_d_q[SQRT_STEPS-1];

	qte_atan_lane #(.STAGES(CORDIC_STAGES)) u_lane_pitch (
		.clk   (clk),
		.y_in  (lp_y),
		.x_in  (lp_x),
		.z_out (z_p)
	);

	qte_atan_lane #(.STAGES(CORDIC_STAGES)) u_lane_yaw (
		.clk   (clk),
		.y_in  (ly_y),
		.x_in  (ly_x),
		.z_out (z_y)
	);

	qte_atan_lane #(.STAGES(CORDIC_STAGES)) u_lane_roll (
		.clk   (clk),
		.y_in  (ry_d_q[SQRT_STEPS-1]),
		.x_in  (rx_d_q[SQRT_STEPS-1]),
		.z_out (z_r)
	);

	// pole substitution and rounding
	pole_case_t         cl;
	logic signed [30:0] a_p, a_y, a_r;

	assign cl = case_d_q[CDLY-1];

	always_comb begin
		case (cl)
			CASE_NORTH: begin
				a_p = 31'(DEG90);
				a_y = 31'(z_y) <<< 1;
				a_r = '0;
			end
			CASE_SOUTH: begin
				a_p = -31'(DEG90);
				a_y = -(31'(z_y) <<< 1);
				a_r = '0;
			end
			default: begin
				a_p = 31'(z_p);
				a_y = 31'(z_y);
				a_r = 31'(z_r);
			end
		endcase
	end

	logic signed [31:0] rp_q, ry_q, rr_q;
	pole_case_t         cr_q;

	always_ff @(posedge clk) begin
		rp_q <= (32'(a_p) + HALF) >>> SH;
		ry_q <= (32'(a_y) + HALF) >>> SH;
		rr_q <= (32'(a_r) + HALF) >>> SH;
		cr_q <= cl;
	end

	// wrap into [0, 360); inputs stay within two turns
	function automatic logic signed [31:0] wrap_turn(input logic signed [31:0] r);
		logic signed [31:0] t;
		t = r;
		if (t < 0)
			t = t + FULL;
		if (t < 0)
			t = t + FULL;
		if (t >= FULL)
			t = t - FULL;
		if (t >= FULL)
			t = t - FULL;
		return t;
	endfunction

	logic signed [31:0] wp, wy, wr;
	logic [15:0]        pitch_q, yaw_q, roll_q;
	pole_case_t         case_q;

	assign wp = wrap_turn(rp_q);
	assign wy = wrap_turn(ry_q);
	assign wr = wrap_turn(rr_q);

	always_ff @(posedge clk) begin
		pitch_q <= wp[15:0];
		yaw_q   <= wy[15:0];
		roll_q  <= wr[15:0];
		case_q  <= cr_q;
	end

	assign done      = vld_q[LAT-1];
	assign pitch_deg = pitch_q;
	assign yaw_deg   = yaw_q;
	assign roll_deg  = roll_q;
	assign pole_case = case_q;

	a_case_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pole_case == CASE_GENERAL || pole_case == CASE_NORTH ||
			pole_case == CASE_SOUTH))
		else $error("pole_case out of range");

	a_pole_roll: assert property (@(posedge clk) disable iff (!arst_n)
		(done && pole_case != CASE_GENERAL) |-> roll_deg == '0)
		else $error("roll not zero at a pole");

	a_north_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		(done && pole_case == CASE_NORTH) |-> pitch_deg == PITCH_N)
		else $error("pitch not 90 at north pole");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without matching input beat");

endmodule
`default_nettype wire

// ----- sim/quaternion_to_euler_degrees_unit_tb.sv -----
// Testbench for quaternion_to_euler_degrees_unit: drives quaternion beats and
// pole_threshold writes, predicts each angle triple in fixed point and compares.
// Depends on rtl/qte_pkg.sv and the RTL of the unit.
`timescale 1ns / 1ps
module quaternion_to_euler_degrees_unit_tb;
	import qte_pkg::*;

	localparam int AFB = 7;
	localparam int STAGES = 16;
	localparam int LATENCY = 42 + STAGES;
	localparam longint DEG_UNIT = 64'sd1 << 20;

	typedef struct packed {
		logic [15:0] pitch;
		logic [15:0] yaw;
		logic [15:0] roll;
		pole_case_t  pcase;
	} angles_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic signed [15:0] quat_x = 0, quat_y = 0, quat_z = 0, quat_w = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [15:0] cfg_data = 0;
	logic done;
	logic [15:0] pitch_deg, yaw_deg, roll_deg;
	pole_case_t pole_case;

	angles_t pending_angles[$];
	logic [15:0] threshold;
	int errors = 0;
	int send_idle_pct = 0;

	quaternion_to_euler_degrees_unit uut (.*);

	initial forever #5 clk = ~clk;

	initial begin
		#50ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint v);
		longint res, bitv;
		res = 0;
		bitv = 64'sd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint atan2_deg(longint y, longint x);
		longint z, m, t, xs, ys, ax, ay;
		z = 0;
		if (x == 0) return y > 0 ? 90 * DEG_UNIT : (y < 0 ? -90 * DEG_UNIT : 0);
		if (y == 0) return x > 0 ? 0 : 180 * DEG_UNIT;
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		m = ax > ay ? ax : ay;
		while (m < (64'sd1 << 40)) begin
			m = m * 2; x = x * 2; y = y * 2;
		end
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = 90 * DEG_UNIT;
			end else begin
				t = x; x = -y; y = t; z = -90 * DEG_UNIT;
			end
		end
		for (int i = 0; i < STAGES; i++) begin
			xs = floor_shift(x, i);
			ys = floor_shift(y, i);
			if (y > 0) begin
				x += ys; y -= xs; z += ATAN_TAB[i];
			end else begin
				x -= ys; y += xs; z -= ATAN_TAB[i];
			end
		end
		return z;
	endfunction

	function automatic logic [15:0] wrap_angle(longint a);
		longint full, r;
		full = 360 * (64'sd1 << AFB);
		r = floor_shift(a + (64'sd1 << (19 - AFB)), 20 - AFB) % full;
		if (r < 0) r += full;
		return r[15:0];
	endfunction

	function automatic angles_t euler_of(logic signed [15:0] qx, logic signed [15:0] qy,
			logic signed [15:0] qz, logic signed [15:0] qw);
		longint x, y, z, w, unitsq, tst, lim, s, c, one;
		angles_t r;
		x = qx; y = qy; z = qz; w = qw;
		one = 64'sd1 << 28;
		unitsq = x * x + y * y + z * z + w * w;
		tst = x * w - y * z;
		lim = longint'(threshold) * unitsq;
		if (tst * 65536 > lim) begin
			r.yaw = wrap_angle(2 * atan2_deg(y, x));
			r.pitch = wrap_angle(90 * DEG_UNIT);
			r.roll = wrap_angle(0);
			r.pcase = CASE_NORTH;
		end else if (tst * 65536 < -lim) begin
			r.yaw = wrap_angle(-2 * atan2_deg(y, x));
			r.pitch = wrap_angle(-90 * DEG_UNIT);
			r.roll = wrap_angle(0);
			r.pcase = CASE_SOUTH;
		end else begin
			s = 2 * tst;
			if (s > one) s = one;
			if (s < -one) s = -one;
			c = int_sqrt(one * one - s * s);
			r.yaw = wrap_angle(atan2_deg(2 * (w * y + z * x), one - 2 * (x * x + y * y)));
			r.pitch = wrap_angle(atan2_deg(s, c));
			r.roll = wrap_angle(atan2_deg(2 * (w * z + x * y), one - 2 * (z * z + x * x)));
			r.pcase = CASE_GENERAL;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		angles_t e;
		if (done) begin
			if (pending_angles.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = pending_angles.pop_front();
				if (pitch_deg !== e.pitch) begin
					$error("pitch_deg expected %0d got %0d", e.pitch, pitch_deg); errors++;
				end
				if (yaw_deg !== e.yaw) begin
					$error("yaw_deg expected %0d got %0d", e.yaw, yaw_deg); errors++;
				end
				if (roll_deg !== e.roll) begin
					$error("roll_deg expected %0d got %0d", e.roll, roll_deg); errors++;
				end
				if (pole_case !== e.pcase) begin
					$error("pole_case expected %0d got %0d", e.pcase, pole_case); errors++;
				end
			end
		end
	end

	task automatic send_quat(logic signed [15:0] qx, logic signed [15:0] qy,
			logic signed [15:0] qz, logic signed [15:0] qw);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		quat_x <= qx; quat_y <= qy; quat_z <= qz; quat_w <= qw;
		do @(posedge clk); while (busy);
		pending_angles.push_back(euler_of(qx, qy, qz, qw));
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (pending_angles.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_threshold(logic [15:0] v);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		threshold = v;
		@(posedge clk);
	endtask

	task automatic test_directed();
		logic signed [15:0] ext[4] = '{16'sh8000, 16'sh7fff, 0, 16'sh4000};
		send_quat(0, 0, 0, 0);
		send_quat(0, 0, 0, 16'sh4000);
		send_quat(16'sh2d41, 0, 0, 16'sh2d41);
		send_quat(16'sh2d41, 0, 0, -16'sh2d41);
		send_quat(-16'sh4000, 0, 0, 0);
		send_quat(0, 16'sh4000, 0, 0);
		send_quat(0, -16'sh4000, 0, 0);
		send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_quat(16'sh8000, 0, 0, 16'sh7fff);
		send_quat(0, 0, 16'sh4000, 0);
		for (int i = 0; i < 4; i++)
			send_quat(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], ext[(i + 3) % 4]);
		send_quat(16'sh2000, 16'sh2000, -16'sh2000, 16'sh2000);
		send_quat(-16'sh2000, 16'sh2000, 16'sh2000, 16'sh2000);
	endtask

	task automatic test_random(int n);
		logic signed [15:0] a, b;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
				1: send_quat(16'($urandom_range(0, 16'h7fff)) - 16'sh4000,
					16'($urandom_range(0, 16'h7fff)) - 16'sh4000,
					16'($urandom_range(0, 16'h7fff)) - 16'sh4000,
					16'($urandom_range(0, 16'h7fff)) - 16'sh4000);
				2: begin
					// near a pole: x ~ +-w, small y/z
					a = 16'($urandom_range(0, 16'h7fff)) - 16'sh4000;
					b = 16'($urandom_range(0, 64)) - 16'sd32;
					send_quat(a, b, 16'($urandom_range(0, 64)) - 16'sd32,
						$urandom_range(0, 1) ? a + b : -a - b);
				end
				default: send_quat(16'($urandom_range(0, 32)) - 16'sd16,
					16'($urandom_range(0, 32)) - 16'sd16,
					16'($urandom_range(0, 32)) - 16'sd16,
					16'($urandom_range(0, 32)) - 16'sd16);
			endcase
		end
	endtask

	task automatic test_thresholds();
		logic [15:0] vals[5] = '{16'd0, 16'd32768, 16'd65535, 16'd16384, 16'd32735};
		foreach (vals[k]) begin
			drain();
			write_threshold(vals[k]);
			test_random(30);
		end
	endtask

	initial begin
		threshold = THR_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_idle_pct = 12;
		test_directed();
		test_random(250);
		drain();
		send_idle_pct = 72;
		test_thresholds();
		test_random(120);
		drain();
		send_idle_pct = 0;
		test_random(280);
		drain();
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
